// File: rtl/modulation_matrix_router_top_assert.svh
// Assertion macros shared by the modulation matrix router checkers.
`ifndef MODULATION_MATRIX_ROUTER_TOP_ASSERT_SVH
`define MODULATION_MATRIX_ROUTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMR_ASSERT_NOW(name, ant, con) \
   name: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("mmr check failed");

// Next-cycle implication, disabled during reset.
`define MMR_ASSERT_NEXT(name, ant, con) \
   name: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("mmr check failed");

// Next-cycle implication that also holds across reset.
`define MMR_ASSERT_RST(name, ant, con) \
   name: assert property (@(posedge clock) (ant) |=> (con)) \
      else $error("mmr check failed");

`endif

// File: rtl/mmr_pkg.sv
// Shared types and constants of the modulation matrix router.
`default_nettype none

package mmr_pkg;

   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int SRC_W   = 3;
   localparam int XFORM_W = 2;
   localparam int DEST_W  = 4;
   localparam int Q_W     = 16;
   localparam int ACC_W   = 21;
   localparam int MASK_W  = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SRC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EVAL = 2'd2;

   localparam logic [XFORM_W-1:0] XF_UNI = 2'd1;
   localparam logic [XFORM_W-1:0] XF_BI  = 2'd2;

   localparam logic CSR_IDX_BIP = 1'b0;

   localparam logic [MASK_W-1:0] BIP_MASK_RST = 8'd3;
   localparam logic [MASK_W-1:0] UNI_MASK_RST = 8'd60;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 21'sd1048575;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -21'sd1048576;

   typedef struct packed {
      logic                  on;
      logic signed [Q_W-1:0] gain;
      logic signed [Q_W-1:0] span;
      logic [DEST_W-1:0]     dest;
      logic [XFORM_W-1:0]    xform;
      logic [SRC_W-1:0]      src;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

`default_nettype wire

// File: rtl/modulation_matrix_router_top.sv
// Modulation matrix router: row table, source bank and destination sums.
//
// An evaluate request walks the row table one slot per cycle through a
// five-stage read/multiply/accumulate pipeline (row read, source read, two
// multiplies, accumulator read-add-write with one-deep forwarding), drains
// that pipeline, then, for each destination in turn, reads the accumulator
// memory and loads its sum into the output register. Each read waits while
// the result side stalls; the read-then-load step for each sum sets the
// emission pace. Valid bits stand in for clearing the memories, so no
// sweep follows reset. A new request is taken once the last sum of an
// evaluation sits in the output register.
`default_nettype none

module modulation_matrix_router_top #(
   parameter int NUM_ROWS    = 16,
   parameter int NUM_SOURCES = 8,
   parameter int NUM_DESTS   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mmr_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [mmr_pkg::SLOT_W-1:0]          req_slot,
   input  wire logic [mmr_pkg::SRC_W-1:0]           req_source_index,
   input  wire logic [mmr_pkg::XFORM_W-1:0]         req_transform_code,
   input  wire logic [mmr_pkg::DEST_W-1:0]          req_dest_index,
   input  wire logic signed [mmr_pkg::Q_W-1:0]      req_range_value,
   input  wire logic signed [mmr_pkg::Q_W-1:0]      req_intensity_value,
   input  wire logic                                req_enabled,
   input  wire logic signed [mmr_pkg::Q_W-1:0]      req_source_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [mmr_pkg::DEST_W-1:0]               rsp_out_dest,
   output logic signed [mmr_pkg::ACC_W-1:0]         rsp_out_value,
   output logic                                     rsp_out_last,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mmr_pkg::CSR_AW-1:0]          csr_paddr,
   input  wire logic [mmr_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [mmr_pkg::CSR_DW-1:0]               csr_prdata,
   output logic                                     csr_pready
);

   localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int SRC_AW = $clog2(NUM_SOURCES);
   localparam int DST_AW = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
   localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(NUM_ROWS - 1);
   localparam logic [DST_AW-1:0] DST_LAST = DST_AW'(NUM_DESTS - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ROWS    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT_LD = 3'd4;

   // control
   logic [2:0]                 state_ff, state_in;
   logic [ROW_AW-1:0]          row_cnt_ff, row_cnt_in;
   logic [DST_AW-1:0]          emit_cnt_ff, emit_cnt_in;
   logic [mmr_pkg::MASK_W-1:0] bip_mask_ff, bip_mask_in;
   logic [mmr_pkg::MASK_W-1:0] uni_mask_ff, uni_mask_in;
   logic [NUM_ROWS-1:0]        row_valid_ff, row_valid_in;
   logic [NUM_SOURCES-1:0]     src_valid_ff, src_valid_in;
   logic [NUM_DESTS-1:0]       acc_valid_ff, acc_valid_in;
   logic                       s1_vld_ff, s1_vld_in;
   logic                       s2_vld_ff, s2_vld_in;
   logic                       s3_vld_ff, s3_vld_in;
   logic                       s4_vld_ff, s4_vld_in;
   logic                       fwd_vld_ff, fwd_vld_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload
   logic                               s1_ok_ff, s1_ok_in;
   logic                               s2_src_ok_ff, s2_src_ok_in;
   logic                               s2_src_wr_ff, s2_src_wr_in;
   logic                               s2_bip_ff, s2_bip_in;
   logic                               s2_uni_ff, s2_uni_in;
   logic [mmr_pkg::XFORM_W-1:0]        s2_xform_ff, s2_xform_in;
   logic [DST_AW-1:0]                  s2_dest_ff, s2_dest_in;
   logic signed [mmr_pkg::Q_W-1:0]     s2_span_ff, s2_span_in;
   logic signed [mmr_pkg::Q_W-1:0]     s2_gain_ff, s2_gain_in;
   logic signed [31:0]                 s3_prod_ff, s3_prod_in;
   logic signed [mmr_pkg::Q_W-1:0]     s3_span_ff, s3_span_in;
   logic [DST_AW-1:0]                  s3_dest_ff, s3_dest_in;
   logic signed [47:0]                 s4_prod_ff, s4_prod_in;
   logic [DST_AW-1:0]                  s4_dest_ff, s4_dest_in;
   logic [DST_AW-1:0]                  fwd_dest_ff, fwd_dest_in;
   logic signed [mmr_pkg::ACC_W-1:0]   fwd_val_ff, fwd_val_in;
   logic [mmr_pkg::DEST_W-1:0]         rsp_dest_ff, rsp_dest_in;
   logic signed [mmr_pkg::ACC_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                               rsp_last_ff, rsp_last_in;

   // memory ports
   mmr_pkg::row_type                   row_wdata;
   mmr_pkg::row_type                   row_rdata;
   logic                               row_wr;
   logic                               row_rd;
   logic                               src_wr;
   logic                               src_rd;
   logic signed [mmr_pkg::Q_W-1:0]     src_rdata;
   logic [SRC_AW-1:0]                  src_raddr;
   logic                               acc_rd;
   logic [DST_AW-1:0]                  acc_raddr;
   logic signed [mmr_pkg::ACC_W-1:0]   acc_rdata;
   logic signed [mmr_pkg::ACC_W-1:0]   acc_new;

   // datapath
   logic                               req_take;
   logic                               csr_wr;
   logic                               s1_go;
   logic                               s1_src_ok;
   logic signed [mmr_pkg::Q_W-1:0]     x_raw;
   logic signed [mmr_pkg::Q_W:0]       x_uni17;
   logic signed [mmr_pkg::Q_W+1:0]     x_bi18;
   logic signed [mmr_pkg::Q_W-1:0]     x_bi;
   logic signed [mmr_pkg::Q_W-1:0]     x_shaped;
   logic signed [17:0]                 prod_q;
   logic signed [mmr_pkg::ACC_W-1:0]   acc_old;
   logic signed [mmr_pkg::ACC_W:0]     acc_sum;
   logic                               out_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mmr_pkg::CSR_IDX_BIP) ?
                       mmr_pkg::CSR_DW'(bip_mask_ff) : mmr_pkg::CSR_DW'(uni_mask_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_dest  = rsp_dest_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

   // row table
   always_comb begin
      row_wdata.on    = req_enabled;
      row_wdata.gain  = req_intensity_value;
      row_wdata.span  = req_range_value;
      row_wdata.dest  = req_dest_index;
      row_wdata.xform = req_transform_code;
      row_wdata.src   = req_source_index;
   end

   assign row_wr = req_take && (req_kind == mmr_pkg::KIND_ROW) && (int'(req_slot) < NUM_ROWS);
   assign row_rd = (state_ff == ST_ROWS);

   mmr_ram #(
      .WIDTH (mmr_pkg::ROW_W),
      .DEPTH (NUM_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr),
      .wr_addr (ROW_AW'(req_slot)),
      .wr_data (row_wdata),
      .rd_en   (row_rd),
      .rd_addr (row_cnt_ff),
      .rd_data (row_rdata)
   );

   // source bank
   assign src_wr = req_take && (req_kind == mmr_pkg::KIND_SRC) &&
                   (int'(req_source_index) < NUM_SOURCES);
   assign s1_go  = s1_vld_ff && s1_ok_ff && row_rdata.on && (int'(row_rdata.dest) < NUM_DESTS);
   assign src_rd = s1_go;
   assign src_raddr = SRC_AW'(row_rdata.src);
   assign s1_src_ok = (int'(row_rdata.src) < NUM_SOURCES);

   mmr_ram #(
      .WIDTH (mmr_pkg::Q_W),
      .DEPTH (NUM_SOURCES)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_wr),
      .wr_addr (SRC_AW'(req_source_index)),
      .wr_data (req_source_value),
      .rd_en   (src_rd),
      .rd_addr (src_raddr),
      .rd_data (src_rdata)
   );

   // polarity shaping
   always_comb begin
      x_raw   = s2_src_wr_ff ? src_rdata : '0;
      x_uni17 = {x_raw[mmr_pkg::Q_W-1], x_raw} + 17'sd32768;
      x_bi18  = {x_raw[mmr_pkg::Q_W-1], x_raw, 1'b0} - 18'sd32768;
      x_bi    = (x_bi18 < -18'sd32768) ? -16'sd32768 : x_bi18[mmr_pkg::Q_W-1:0];
      if (!s2_src_ok_ff) begin
         x_shaped = '0;
      end else if (s2_bip_ff) begin
         x_shaped = (s2_xform_ff == mmr_pkg::XF_UNI) ? x_uni17[mmr_pkg::Q_W:1] : x_raw;
      end else if (s2_uni_ff) begin
         x_shaped = (s2_xform_ff == mmr_pkg::XF_BI) ? x_bi : x_raw;
      end else begin
         x_shaped = x_raw;
      end
   end

   // accumulate
   assign acc_rd    = (state_ff == ST_EMIT_RD) ? out_free : s3_vld_ff;
   assign acc_raddr = (state_ff == ST_EMIT_RD) ? emit_cnt_ff : s3_dest_ff;

   always_comb begin
      prod_q = $signed(s4_prod_ff[47:30]);
      if (fwd_vld_ff && (fwd_dest_ff == s4_dest_ff)) begin
         acc_old = fwd_val_ff;
      end else if (acc_valid_ff[s4_dest_ff]) begin
         acc_old = acc_rdata;
      end else begin
         acc_old = '0;
      end
      acc_sum = {acc_old[mmr_pkg::ACC_W-1], acc_old} + {{4{prod_q[17]}}, prod_q};
      if (acc_sum[mmr_pkg::ACC_W] != acc_sum[mmr_pkg::ACC_W-1]) begin
         acc_new = acc_sum[mmr_pkg::ACC_W] ? mmr_pkg::ACC_MIN : mmr_pkg::ACC_MAX;
      end else begin
         acc_new = acc_sum[mmr_pkg::ACC_W-1:0];
      end
   end

   mmr_ram #(
      .WIDTH (mmr_pkg::ACC_W),
      .DEPTH (NUM_DESTS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s4_vld_ff),
      .wr_addr (s4_dest_ff),
      .wr_data (acc_new),
      .rd_en   (acc_rd),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   // next state
   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      bip_mask_in  = bip_mask_ff;
      uni_mask_in  = uni_mask_ff;
      row_valid_in = row_valid_ff;
      src_valid_in = src_valid_ff;
      acc_valid_in = acc_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dest_in  = rsp_dest_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr) begin
         if (csr_paddr[2] == mmr_pkg::CSR_IDX_BIP) begin
            bip_mask_in = csr_pwdata[mmr_pkg::MASK_W-1:0];
         end else begin
            uni_mask_in = csr_pwdata[mmr_pkg::MASK_W-1:0];
         end
      end

      if (row_wr) begin
         row_valid_in[ROW_AW'(req_slot)] = 1'b1;
      end
      if (src_wr) begin
         src_valid_in[SRC_AW'(req_source_index)] = 1'b1;
      end
      if (s4_vld_ff) begin
         acc_valid_in[s4_dest_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_kind == mmr_pkg::KIND_EVAL)) begin
               acc_valid_in = '0;
               row_cnt_in   = '0;
               state_in     = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (row_cnt_ff == ROW_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               row_cnt_in = row_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff && !s4_vld_ff) begin
               emit_cnt_in = '0;
               state_in    = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            if (out_free) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_dest_in  = mmr_pkg::DEST_W'(emit_cnt_ff);
            rsp_value_in = acc_valid_ff[emit_cnt_ff] ? acc_rdata : '0;
            rsp_last_in  = (emit_cnt_ff == DST_LAST);
            if (emit_cnt_ff == DST_LAST) begin
               state_in = ST_IDLE;
            end else begin
               emit_cnt_in = emit_cnt_ff + 1'b1;
               state_in    = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pipeline next values
   always_comb begin
      s1_vld_in    = row_rd;
      s1_ok_in     = row_valid_ff[row_cnt_ff];
      s2_vld_in    = s1_go;
      s2_src_ok_in = s1_src_ok;
      s2_src_wr_in = s1_src_ok && src_valid_ff[src_raddr];
      s2_bip_in    = bip_mask_ff[row_rdata.src];
      s2_uni_in    = uni_mask_ff[row_rdata.src];
      s2_xform_in  = row_rdata.xform;
      s2_dest_in   = DST_AW'(row_rdata.dest);
      s2_span_in   = row_rdata.span;
      s2_gain_in   = row_rdata.gain;
      s3_vld_in    = s2_vld_ff;
      s3_prod_in   = x_shaped * s2_gain_ff;
      s3_span_in   = s2_span_ff;
      s3_dest_in   = s2_dest_ff;
      s4_vld_in    = s3_vld_ff;
      s4_prod_in   = s3_prod_ff * s3_span_ff;
      s4_dest_in   = s3_dest_ff;
      fwd_vld_in   = s4_vld_ff;
      fwd_dest_in  = s4_dest_ff;
      fwd_val_in   = acc_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_cnt_ff   <= '0;
         emit_cnt_ff  <= '0;
         bip_mask_ff  <= mmr_pkg::BIP_MASK_RST;
         uni_mask_ff  <= mmr_pkg::UNI_MASK_RST;
         row_valid_ff <= '0;
         src_valid_ff <= '0;
         acc_valid_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         bip_mask_ff  <= bip_mask_in;
         uni_mask_ff  <= uni_mask_in;
         row_valid_ff <= row_valid_in;
         src_valid_ff <= src_valid_in;
         acc_valid_ff <= acc_valid_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         s4_vld_ff    <= s4_vld_in;
         fwd_vld_ff   <= fwd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff     <= s1_ok_in;
      s2_src_ok_ff <= s2_src_ok_in;
      s2_src_wr_ff <= s2_src_wr_in;
      s2_bip_ff    <= s2_bip_in;
      s2_uni_ff    <= s2_uni_in;
      s2_xform_ff  <= s2_xform_in;
      s2_dest_ff   <= s2_dest_in;
      s2_span_ff   <= s2_span_in;
      s2_gain_ff   <= s2_gain_in;
      s3_prod_ff   <= s3_prod_in;
      s3_span_ff   <= s3_span_in;
      s3_dest_ff   <= s3_dest_in;
      s4_prod_ff   <= s4_prod_in;
      s4_dest_ff   <= s4_dest_in;
      fwd_dest_ff  <= fwd_dest_in;
      fwd_val_ff   <= fwd_val_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

// File: rtl/mmr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mmr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/mmr_checker.sv
// Port-level checker for the modulation matrix router and its bind.
`default_nettype none

`include "modulation_matrix_router_top_assert.svh"

module mmr_checker #(
   parameter int NUM_DESTS = 16
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic [mmr_pkg::KIND_W-1:0]      req_kind,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mmr_pkg::DEST_W-1:0]      rsp_out_dest,
   input wire logic [mmr_pkg::ACC_W-1:0]       rsp_out_value,
   input wire logic                            rsp_out_last
);

   `MMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_dest) && $stable(rsp_out_value) && $stable(rsp_out_last))

   `MMR_ASSERT_RST(a_rsp_reset, reset, !rsp_valid)

   `MMR_ASSERT_NEXT(a_eval_busy, req_valid && req_ready && (req_kind == mmr_pkg::KIND_EVAL), !req_ready)

   `MMR_ASSERT_NOW(a_last_dest, rsp_valid && rsp_out_last, rsp_out_dest == mmr_pkg::DEST_W'(NUM_DESTS - 1))

endmodule

bind modulation_matrix_router_top mmr_checker #(
   .NUM_DESTS (NUM_DESTS)
) u_mmr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_dest  (rsp_out_dest),
   .rsp_out_value (rsp_out_value),
   .rsp_out_last  (rsp_out_last)
);

`default_nettype wire
